FILE: rtl/gbfr_pkg.sv
// Shared types and constants for the GNSS binary frame receiver.
package gbfr_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [31:0] STALE_LIMIT_RESET    = 32'd2000000;
  localparam logic [7:0]  POSITION_CLASS_RESET = 8'd1;
  localparam logic [7:0]  POSITION_ID_RESET    = 8'd7;
  localparam logic [31:0] AGE_MAX              = 32'hFFFF_FFFF;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_STALE_LIMIT    = 2'd0;
  localparam logic [1:0] REG_POSITION_CLASS = 2'd1;
  localparam logic [1:0] REG_POSITION_ID    = 2'd2;

  // Slots of the captured and published value sets
  localparam logic [1:0] SLOT_LAT   = 2'd0;
  localparam logic [1:0] SLOT_LON   = 2'd1;
  localparam logic [1:0] SLOT_NORTH = 2'd2;
  localparam logic [1:0] SLOT_EAST  = 2'd3;

  typedef enum logic [1:0] {
    STATUS_POSITION_OK = 2'd0,
    STATUS_OTHER       = 2'd1,
    STATUS_BAD_CHECK   = 2'd2,
    STATUS_STALE       = 2'd3
  } status_t;

  typedef logic [3:0][31:0] field_set_t;

  typedef struct packed {
    logic        done;
    logic        good_position;
    status_t     status;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] msg_length;
  } frame_result_t;

endpackage

FILE: rtl/gbfr_parser.sv
// Frame parser: sync hunt, header, Fletcher sum, payload capture and publish.
module gbfr_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_valid,
  input  logic [7:0]              data_byte,
  input  logic [7:0]              position_class,
  input  logic [7:0]              position_id,
  output gbfr_pkg::frame_result_t result,
  output gbfr_pkg::field_set_t    published_next
);

  typedef enum logic [2:0] {
    HUNT, CLASS, ID, LEN_LO, LEN_HI, PAYLOAD, CHECK_A, CHECK_B
  } phase_t;

  phase_t               phase, phase_next;
  logic [7:0]           previous_byte, previous_byte_next;
  logic [7:0]           frame_class, frame_class_next;
  logic [7:0]           frame_id, frame_id_next;
  logic [15:0]          frame_length, frame_length_next;
  logic [15:0]          byte_index, byte_index_next;
  logic [7:0]           sum_a, sum_a_next;
  logic [7:0]           sum_b, sum_b_next;
  logic [7:0]           received_check_a, received_check_a_next;
  gbfr_pkg::field_set_t capture, capture_next;
  gbfr_pkg::field_set_t published;

  logic [7:0]  sum_a_add, sum_b_add;
  logic [15:0] index_inc;
  logic [15:0] length_full;
  logic        in_low, in_high;
  logic [1:0]  slot;

  assign sum_a_add   = sum_a + data_byte;
  assign sum_b_add   = sum_b + sum_a_add;
  assign index_inc   = byte_index + 16'd1;
  assign length_full = {data_byte, frame_length[7:0]};
  // Payload bytes 24..31 and 48..55 land in the capture set
  assign in_low      = (byte_index[15:3] == 13'd3);
  assign in_high     = (byte_index[15:3] == 13'd6);

  always_comb begin
    if (in_high) begin
      slot = byte_index[2] ? gbfr_pkg::SLOT_EAST : gbfr_pkg::SLOT_NORTH;
    end else begin
      slot = byte_index[2] ? gbfr_pkg::SLOT_LAT : gbfr_pkg::SLOT_LON;
    end
  end

  always_comb begin
    phase_next            = phase;
    previous_byte_next    = previous_byte;
    frame_class_next      = frame_class;
    frame_id_next         = frame_id;
    frame_length_next     = frame_length;
    byte_index_next       = byte_index;
    sum_a_next            = sum_a;
    sum_b_next            = sum_b;
    received_check_a_next = received_check_a;
    capture_next          = capture;
    published_next        = published;
    result                = '0;

    if (byte_valid) begin
      case (phase)
        HUNT: begin
          if (previous_byte == gbfr_pkg::SYNC_FIRST && data_byte == gbfr_pkg::SYNC_SECOND) begin
            phase_next         = CLASS;
            sum_a_next         = 8'd0;
            sum_b_next         = 8'd0;
            byte_index_next    = 16'd0;
            capture_next       = '0;
            previous_byte_next = 8'd0;
          end else begin
            previous_byte_next = data_byte;
          end
        end
        CLASS: begin
          frame_class_next = data_byte;
          sum_a_next       = sum_a_add;
          sum_b_next       = sum_b_add;
          phase_next       = ID;
        end
        ID: begin
          frame_id_next = data_byte;
          sum_a_next    = sum_a_add;
          sum_b_next    = sum_b_add;
          phase_next    = LEN_LO;
        end
        LEN_LO: begin
          frame_length_next = {8'd0, data_byte};
          sum_a_next        = sum_a_add;
          sum_b_next        = sum_b_add;
          phase_next        = LEN_HI;
        end
        LEN_HI: begin
          frame_length_next = length_full;
          sum_a_next        = sum_a_add;
          sum_b_next        = sum_b_add;
          phase_next        = (length_full == 16'd0) ? CHECK_A : PAYLOAD;
        end
        PAYLOAD: begin
          if (in_low || in_high) begin
            capture_next[slot][{byte_index[1:0], 3'b000} +: 8] = data_byte;
          end
          sum_a_next      = sum_a_add;
          sum_b_next      = sum_b_add;
          byte_index_next = index_inc;
          if (index_inc >= frame_length) begin
            phase_next = CHECK_A;
          end
        end
        CHECK_A: begin
          received_check_a_next = data_byte;
          phase_next            = CHECK_B;
        end
        CHECK_B: begin
          phase_next         = HUNT;
          previous_byte_next = 8'd0;
          result.done        = 1'b1;
          result.msg_class   = frame_class;
          result.msg_id      = frame_id;
          result.msg_length  = frame_length;
          if (received_check_a != sum_a || data_byte != sum_b) begin
            result.status = gbfr_pkg::STATUS_BAD_CHECK;
          end else if (frame_class == position_class && frame_id == position_id) begin
            result.status        = gbfr_pkg::STATUS_POSITION_OK;
            result.good_position = 1'b1;
            published_next       = capture;
          end else begin
            result.status = gbfr_pkg::STATUS_OTHER;
          end
        end
        default: begin
          phase_next = HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= HUNT;
      previous_byte    <= 8'd0;
      frame_class      <= 8'd0;
      frame_id         <= 8'd0;
      frame_length     <= 16'd0;
      byte_index       <= 16'd0;
      sum_a            <= 8'd0;
      sum_b            <= 8'd0;
      received_check_a <= 8'd0;
      capture          <= '0;
      published        <= '0;
    end else begin
      phase            <= phase_next;
      previous_byte    <= previous_byte_next;
      frame_class      <= frame_class_next;
      frame_id         <= frame_id_next;
      frame_length     <= frame_length_next;
      byte_index       <= byte_index_next;
      sum_a            <= sum_a_next;
      sum_b            <= sum_b_next;
      received_check_a <= received_check_a_next;
      capture          <= capture_next;
      published        <= published_next;
    end
  end

endmodule

FILE: rtl/gnss_binary_frame_receiver_unit.sv
// A result appears in the output register in the cycle after the word that causes it.
// Throughput: one word (byte or tick) per cycle while in_ready is high, set by the single parser state update.
// A word is taken while a result waits, provided that result leaves in the same cycle.
// Reset (synchronous, active high): parser hunts for sync, captures, published values,
// age and stale flag clear, registers return to limit 2000000, class 1, id 7.
module gnss_binary_frame_receiver_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [7:0]         msg_class,
  output logic [7:0]         msg_id,
  output logic [15:0]        msg_length,
  output logic signed [31:0] latitude,
  output logic signed [31:0] longitude,
  output logic signed [31:0] vel_north,
  output logic signed [31:0] vel_east,
  output logic               is_stale
);

  logic [31:0] stale_limit;
  logic [7:0]  position_class;
  logic [7:0]  position_id;
  logic [31:0] age_ticks, age_ticks_next;
  logic        stale_reported, stale_reported_next;

  logic                    accept, tick, byte_valid;
  logic [31:0]             age_inc;
  logic                    over;
  logic                    emit;
  gbfr_pkg::frame_result_t frame;
  gbfr_pkg::field_set_t    published_next;
  gbfr_pkg::status_t       status_next;
  logic [7:0]              class_next, id_next;
  logic [15:0]             length_next;

  logic [1:0]  status_r;
  logic [7:0]  class_r, id_r;
  logic [15:0] length_r;
  gbfr_pkg::field_set_t fields_r;
  logic        stale_r;

  assign in_ready   = !out_valid || out_ready;
  assign accept     = in_valid && in_ready;
  assign tick       = accept && kind;
  assign byte_valid = accept && !kind;

  gbfr_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .data_byte      (data_byte),
    .position_class (position_class),
    .position_id    (position_id),
    .result         (frame),
    .published_next (published_next)
  );

  // Saturate the age at its top value
  assign age_inc = (age_ticks == gbfr_pkg::AGE_MAX) ? age_ticks : age_ticks + 32'd1;
  assign over    = age_inc > stale_limit;

  always_comb begin
    age_ticks_next      = age_ticks;
    stale_reported_next = stale_reported;
    emit                = 1'b0;
    status_next         = gbfr_pkg::STATUS_STALE;
    class_next          = 8'd0;
    id_next             = 8'd0;
    length_next         = 16'd0;
    if (tick) begin
      age_ticks_next = age_inc;
      if (over) begin
        if (!stale_reported) begin
          stale_reported_next = 1'b1;
          emit                = 1'b1;
        end
      end else begin
        stale_reported_next = 1'b0;
      end
    end
    if (frame.done) begin
      emit        = 1'b1;
      status_next = frame.status;
      class_next  = frame.msg_class;
      id_next     = frame.msg_id;
      length_next = frame.msg_length;
      if (frame.good_position) begin
        age_ticks_next      = 32'd0;
        stale_reported_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit    <= gbfr_pkg::STALE_LIMIT_RESET;
      position_class <= gbfr_pkg::POSITION_CLASS_RESET;
      position_id    <= gbfr_pkg::POSITION_ID_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        gbfr_pkg::REG_STALE_LIMIT:    stale_limit    <= cfg_data;
        gbfr_pkg::REG_POSITION_CLASS: position_class <= cfg_data[7:0];
        gbfr_pkg::REG_POSITION_ID:    position_id    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age_ticks      <= 32'd0;
      stale_reported <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      age_ticks      <= age_ticks_next;
      stale_reported <= stale_reported_next;
      if (accept && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result word; hold it until taken
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      status_r <= status_next;
      class_r  <= class_next;
      id_r     <= id_next;
      length_r <= length_next;
      fields_r <= published_next;
      stale_r  <= (age_ticks_next > stale_limit);
    end
  end

  assign status     = status_r;
  assign msg_class  = class_r;
  assign msg_id     = id_r;
  assign msg_length = length_r;
  assign latitude   = $signed(fields_r[gbfr_pkg::SLOT_LAT]);
  assign longitude  = $signed(fields_r[gbfr_pkg::SLOT_LON]);
  assign vel_north  = $signed(fields_r[gbfr_pkg::SLOT_NORTH]);
  assign vel_east   = $signed(fields_r[gbfr_pkg::SLOT_EAST]);
  assign is_stale   = stale_r;

endmodule
